// File: src/ded_pkg.sv
// ----------------------------------------------------------------------------
// ded_pkg
// shared types, function codes and status codes for the searchable deque
// ----------------------------------------------------------------------------
package ded_pkg;

  localparam int unsigned DED_DEPTH = 16;

  localparam logic [2:0] FUNC_PUSH_FRONT = 3'd0;
  localparam logic [2:0] FUNC_PUSH_BACK  = 3'd1;
  localparam logic [2:0] FUNC_POP_FRONT  = 3'd2;
  localparam logic [2:0] FUNC_POP_BACK   = 3'd3;
  localparam logic [2:0] FUNC_SEARCH     = 3'd4;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_FULL      = 2'd1;
  localparam logic [1:0] STAT_EMPTY     = 2'd2;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic [2:0]         func;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] data_out;
    logic [3:0]         position;
    logic [1:0]         status;
    logic [4:0]         occupancy;
  } out_item_t;

  typedef struct packed {
    logic shift_r;
    logic shift_l;
  } cell_ctl_t;

endpackage

// File: src/ded_cell.sv
// ----------------------------------------------------------------------------
// ded_cell
// one entry of the deque chain; loads, or takes a neighbor's entry
// ----------------------------------------------------------------------------
module ded_cell (
  input  logic               clk,
  input  ded_pkg::cell_ctl_t ctl,
  input  logic               load,
  input  logic signed [31:0] load_data,
  input  logic signed [31:0] left_data,
  input  logic signed [31:0] right_data,
  output logic signed [31:0] data
);

  logic signed [31:0] data_r;

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end else if (ctl.shift_r) begin
      data_r <= left_data;
    end else if (ctl.shift_l) begin
      data_r <= right_data;
    end
  end

  assign data = data_r;

endmodule

// File: src/double_ended_list_with_search_top.sv
// ----------------------------------------------------------------------------
// double_ended_list_with_search_top
// bounded deque of signed 32-bit entries with front-to-back search
// ----------------------------------------------------------------------------
// Entries sit in a chain of DEPTH cells in list order, front in cell 0. A push
// or pop updates the chain when accepted and its result is registered on the
// output; a pending stage lets one more transaction in while a result waits on
// the output. A search first captures the key, then the whole chain rotates
// one cell per cycle past the compare at cell 0 and ends back in its original
// order, so a search walks the whole chain whether or not it hits early.
module double_ended_list_with_search_top #(
  parameter int unsigned DEPTH = ded_pkg::DED_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  ded_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output ded_pkg::out_item_t  out_data
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned IDX_W = $clog2(DEPTH);

  localparam logic ST_IDLE   = 1'b0;
  localparam logic ST_SEARCH = 1'b1;

  logic                state_r, state_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [IDX_W-1:0]    idx_r;
  logic [IDX_W-1:0]    pos_r;
  logic                found_r;
  logic signed [31:0]  key_r;
  logic                out_valid_r;
  ded_pkg::out_item_t  out_data_r;
  logic                pend_valid_r;
  ded_pkg::out_item_t  pend_r;

  logic signed [31:0]  cell_q [DEPTH];
  logic [DEPTH-1:0]    cell_load;
  ded_pkg::cell_ctl_t  ctl;

  logic                accept;
  logic                is_full;
  logic                is_empty;
  logic signed [31:0]  tail_data;
  logic                hit;
  logic                search_done;
  logic                new_valid;
  ded_pkg::out_item_t  new_item;
  logic                out_free;

  assign accept   = in_valid && !in_stall;
  assign is_full  = (count_r == CNT_W'(DEPTH));
  assign is_empty = (count_r == '0);
  assign in_stall = (state_r == ST_SEARCH) || pend_valid_r;
  assign out_free = !out_valid_r || !out_stall;

  assign ctl.shift_r = accept && (in_data.func == ded_pkg::FUNC_PUSH_FRONT) && !is_full;
  assign ctl.shift_l = (accept && (in_data.func == ded_pkg::FUNC_POP_FRONT) && !is_empty) ||
                       (state_r == ST_SEARCH);

  // cell chain
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    localparam int unsigned NEXT = (g + 1) % DEPTH;
    logic signed [31:0] left_d;

    if (g == 0) begin : g_head
      assign left_d = in_data.value;
    end else begin : g_body
      assign left_d = cell_q[g-1];
    end

    assign cell_load[g] = accept && (in_data.func == ded_pkg::FUNC_PUSH_BACK) && !is_full &&
                          (count_r == CNT_W'(g));

    ded_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .load       (cell_load[g]),
      .load_data  (in_data.value),
      .left_data  (left_d),
      .right_data (cell_q[NEXT]),
      .data       (cell_q[g])
    );
  end

  // back entry select
  always_comb begin
    tail_data = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (count_r == CNT_W'(i + 1)) begin
        tail_data = tail_data | cell_q[i];
      end
    end
  end

  assign hit = (state_r == ST_SEARCH) && !found_r && (CNT_W'(idx_r) < count_r) &&
               (cell_q[0] == key_r);
  assign search_done = (state_r == ST_SEARCH) && (idx_r == IDX_W'(DEPTH - 1));

  always_comb begin
    count_nxt = count_r;
    state_nxt = state_r;
    new_valid = 1'b0;
    new_item  = '0;
    if (state_r == ST_SEARCH) begin
      new_item.occupancy = 5'(count_r);
      if (found_r) begin
        new_item.data_out = key_r;
        new_item.position = 4'(pos_r);
        new_item.status   = ded_pkg::STAT_OK;
      end else if (hit) begin
        new_item.data_out = key_r;
        new_item.position = 4'(idx_r);
        new_item.status   = ded_pkg::STAT_OK;
      end else begin
        new_item.status   = ded_pkg::STAT_NOT_FOUND;
      end
      if (search_done) begin
        new_valid = 1'b1;
        state_nxt = ST_IDLE;
      end
    end else if (accept) begin
      new_valid = 1'b1;
      case (in_data.func)
        ded_pkg::FUNC_PUSH_FRONT, ded_pkg::FUNC_PUSH_BACK: begin
          if (is_full) begin
            new_item.status = ded_pkg::STAT_FULL;
          end else begin
            count_nxt = count_r + 1'b1;
          end
        end
        ded_pkg::FUNC_POP_FRONT: begin
          if (is_empty) begin
            new_item.status = ded_pkg::STAT_EMPTY;
          end else begin
            new_item.data_out = cell_q[0];
            count_nxt = count_r - 1'b1;
          end
        end
        ded_pkg::FUNC_POP_BACK: begin
          if (is_empty) begin
            new_item.status = ded_pkg::STAT_EMPTY;
          end else begin
            new_item.data_out = tail_data;
            count_nxt = count_r - 1'b1;
          end
        end
        ded_pkg::FUNC_SEARCH: begin
          new_valid = 1'b0;
          state_nxt = ST_SEARCH;
        end
        default: begin
        end
      endcase
      new_item.occupancy = 5'(count_nxt);
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      count_r      <= '0;
      out_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (out_free) begin
        out_valid_r  <= pend_valid_r || new_valid;
        pend_valid_r <= 1'b0;
      end else if (new_valid) begin
        pend_valid_r <= 1'b1;
      end
    end
  end

  // search walk and result payload
  always_ff @(posedge clk) begin
    if (accept && (in_data.func == ded_pkg::FUNC_SEARCH)) begin
      key_r   <= in_data.value;
      idx_r   <= '0;
      found_r <= 1'b0;
    end else if (state_r == ST_SEARCH) begin
      idx_r <= idx_r + 1'b1;
      if (hit) begin
        found_r <= 1'b1;
        pos_r   <= idx_r;
      end
    end
    if (out_free) begin
      out_data_r <= pend_valid_r ? pend_r : new_item;
    end else if (new_valid) begin
      pend_r <= new_item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  a_pend_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    pend_valid_r |-> out_valid_r)
    else $error("pending result without an output transaction");

  a_search_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SEARCH) |-> !pend_valid_r)
    else $error("search running with a pending result");

  a_search_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SEARCH) |=> (count_r == $past(count_r)))
    else $error("entry count changed during search");

endmodule
